FILE: hw/rtl/sd2a_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sd2a_pkg;

	localparam logic [7:0] MINUS_CODE = 8'd45;
	localparam logic [7:0] DIGIT_BASE = 8'd48;
	localparam logic [7:0] DIGIT_MAX  = 8'd57;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CONV,
		ST_SKIP,
		ST_SIGN,
		ST_DIGIT
	} state_t;

	// Commands from the sequencer to the shared shift unit.
	typedef struct packed {
		logic load;
		logic step;
		logic next_digit;
	} dd_cmd_t;

endpackage

`default_nettype wire

FILE: hw/rtl/sd2a_dabble.sv
`timescale 1ns / 1ps
`default_nettype none

module sd2a_dabble
	import sd2a_pkg::*;
#(
	parameter int VALUE_BITS = 32
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire dd_cmd_t               cmd,
	input  wire logic [VALUE_BITS-1:0] load_value,
	output logic      [3:0]            top_digit
);

	// Enough decimal digits for 2^(VALUE_BITS-1); extra leading zeros are harmless.
	localparam int NDIG = (VALUE_BITS * 3) / 10 + 1;
	localparam int BCDW = NDIG * 4;

	logic [VALUE_BITS-1:0] bin_q;
	logic [BCDW-1:0]       bcd_q;
	logic [BCDW-1:0]       bcd_adj;

	// Add three to every digit of five or more before each doubling.
	always_comb begin
		for (int i = 0; i < NDIG; i++) begin
			if (bcd_q[i*4 +: 4] >= 4'd5) begin
				bcd_adj[i*4 +: 4] = bcd_q[i*4 +: 4] + 4'd3;
			end else begin
				bcd_adj[i*4 +: 4] = bcd_q[i*4 +: 4];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bin_q <= '0;
			bcd_q <= '0;
		end else if (cmd.load) begin
			bin_q <= load_value;
			bcd_q <= '0;
		end else if (cmd.step) begin
			bin_q <= {bin_q[VALUE_BITS-2:0], 1'b0};
			bcd_q <= {bcd_adj[BCDW-2:0], bin_q[VALUE_BITS-1]};
		end else if (cmd.next_digit) begin
			bcd_q <= {bcd_q[BCDW-5:0], 4'd0};
		end
	end

	assign top_digit = bcd_q[BCDW-1 -: 4];

endmodule

`default_nettype wire

FILE: hw/rtl/signed_integer_to_decimal_ascii_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Signed binary to decimal ASCII converter.
// The input channel (in_valid, in_ready, value) takes one two's complement
// number. The output channel (out_valid, out_ready, character, last) returns
// its decimal text, most significant digit first: '-' first for a negative
// number, no leading zeros, a single '0' for zero, and last set on the final
// character of the run.
// A number is shifted bit by bit through the shared shift-and-add-three
// unit; the sequencer then drops the suppressed leading zeros, leaves that
// scan, emits a minus sign for a negative number and then each digit. Every
// one of the NDIG digit positions (ten at 32 bits) is either skipped or
// emitted. The next number is taken only once the final character of the
// last one is registered and the sequencer is idle again, as there is a
// single shift unit. in_ready is high only while idle.
// When the receiver stalls, the sequencer waits with the next character, and
// the next number may be taken while the final character still waits. Reset
// empties the output register and returns the sequencer to idle.
module signed_integer_to_decimal_ascii_unit
	import sd2a_pkg::*;
#(
	parameter int VALUE_BITS = 32
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic [VALUE_BITS-1:0] value,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic      [7:0]            character,
	output logic                       last
);

	localparam int NDIG = (VALUE_BITS * 3) / 10 + 1;
	localparam int CW   = $clog2(VALUE_BITS + 1);

	state_t state_q, state_d;
	logic [CW-1:0] cnt_q, cnt_d;
	logic neg_q, neg_d;
	logic out_valid_q;
	logic [7:0] character_q;
	logic last_q;

	logic emit;
	logic [7:0] emit_char;
	logic emit_last;
	logic can_emit;
	logic [3:0] top_digit;
	logic [VALUE_BITS-1:0] magnitude;
	dd_cmd_t cmd;

	assign magnitude = value[VALUE_BITS-1] ? (~value + VALUE_BITS'(1)) : value;
	assign can_emit  = !out_valid_q || out_ready;

	sd2a_dabble #(
		.VALUE_BITS(VALUE_BITS)
	) u_dabble (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.load_value(magnitude),
		.top_digit (top_digit)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			neg_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			neg_q   <= neg_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cnt_d     = cnt_q;
		neg_d     = neg_q;
		cmd       = '0;
		in_ready  = 1'b0;
		emit      = 1'b0;
		emit_char = DIGIT_BASE + {4'd0, top_digit};
		emit_last = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					neg_d    = value[VALUE_BITS-1];
					cnt_d    = CW'(VALUE_BITS);
					state_d  = ST_CONV;
				end
			end
			ST_CONV: begin
				cmd.step = 1'b1;
				cnt_d    = cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					cnt_d   = CW'(NDIG);
					state_d = ST_SKIP;
				end
			end
			ST_SKIP: begin
				// Drop leading zeros but always keep the final digit.
				if (top_digit == 4'd0 && cnt_q != CW'(1)) begin
					cmd.next_digit = 1'b1;
					cnt_d          = cnt_q - CW'(1);
				end else begin
					state_d = neg_q ? ST_SIGN : ST_DIGIT;
				end
			end
			ST_SIGN: begin
				if (can_emit) begin
					emit      = 1'b1;
					emit_char = MINUS_CODE;
					state_d   = ST_DIGIT;
				end
			end
			ST_DIGIT: begin
				if (can_emit) begin
					emit           = 1'b1;
					emit_last      = (cnt_q == CW'(1));
					cmd.next_digit = 1'b1;
					cnt_d          = cnt_q - CW'(1);
					if (cnt_q == CW'(1)) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			character_q <= emit_char;
			last_q      <= emit_last;
		end
	end

	assign out_valid = out_valid_q;
	assign character = character_q;
	assign last      = last_q;

	// The block stays busy for the whole conversion after taking a number.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("in_ready high right after a transaction was accepted");

	// The digit counter never runs out while characters remain to be produced.
	a_cnt_live: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SKIP || state_q == ST_SIGN || state_q == ST_DIGIT) |-> cnt_q != '0)
		else $error("digit counter empty during emission");

	// Every character is either a minus sign or a decimal digit.
	a_char_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (character == MINUS_CODE ||
			(character >= DIGIT_BASE && character <= DIGIT_MAX)))
		else $error("character is neither minus nor digit");

	// A minus sign is never the end of a run.
	a_minus_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && character == MINUS_CODE) |-> !last)
		else $error("minus sign flagged as last character");

endmodule

`default_nettype wire

FILE: sim/signed_integer_to_decimal_ascii_unit_test.sv
`timescale 1ns / 1ps

module signed_integer_to_decimal_ascii_unit_test;
	import sd2a_pkg::*;

	localparam int VALUE_BITS  = 32;
	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int HOLD_CYCLES = 400;
	localparam int DRAIN_WAIT  = 150;
	localparam int MAX_REPORTS = 10;

	typedef struct {
		logic [7:0] code;
		logic       last_flag;
	} text_char_t;

	logic                  clk;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	logic [VALUE_BITS-1:0] value = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic [7:0]            character;
	logic                  last;

	logic [VALUE_BITS-1:0] numbers_to_send[$];
	text_char_t            pending_text[$];

	int  tx_idle_pct = 0;
	int  rx_idle_pct = 0;
	int  queued_count = 0;
	int  accepted_count = 0;
	int  negative_count = 0;
	int  chars_checked = 0;
	int  error_count = 0;
	int  cycle_count = 0;
	int  hold_request = 0;
	int  hold_served = 0;
	int  hold_left = 0;
	logic in_fire = 1'b0;

	signed_integer_to_decimal_ascii_unit #(
		.VALUE_BITS(VALUE_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.value(value),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.character(character),
		.last(last)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Expected text of one number: optional minus, then the digits of the
	// magnitude with no leading zeros. The magnitude is unsigned, so the most
	// negative number negates to itself and prints correctly.
	function automatic void append_decimal_text(logic [VALUE_BITS-1:0] number);
		logic                  negative;
		logic [VALUE_BITS-1:0] magnitude;
		logic [7:0]            digit_codes[$];
		text_char_t            ch;
		negative = number[VALUE_BITS-1];
		magnitude = negative ? -number : number;
		do begin
			digit_codes.push_front(DIGIT_BASE + 8'(magnitude % 10));
			magnitude = magnitude / 10;
		end while (magnitude != 0);
		if (negative) begin
			ch.code = MINUS_CODE;
			ch.last_flag = 1'b0;
			pending_text.push_back(ch);
		end
		foreach (digit_codes[i]) begin
			ch.code = digit_codes[i];
			ch.last_flag = (i == digit_codes.size() - 1);
			pending_text.push_back(ch);
		end
	endfunction

	function automatic logic [VALUE_BITS-1:0] pick_number();
		longint unsigned       decade;
		logic [VALUE_BITS-1:0] magnitude;
		int                    k;
		decade = 1;
		case ($urandom_range(3))
			0: begin
				return $urandom;
			end
			1: begin
				// Uniform digit count, so short runs are as common as long ones.
				k = $urandom_range(1, 9);
				repeat (k) decade = decade * 10;
				magnitude = VALUE_BITS'($urandom % decade);
				return $urandom_range(1) ? -magnitude : magnitude;
			end
			2: begin
				k = $urandom_range(0, 9);
				repeat (k) decade = decade * 10;
				magnitude = VALUE_BITS'(decade) + VALUE_BITS'($urandom_range(2)) - 1;
				return $urandom_range(1) ? -magnitude : magnitude;
			end
			default: begin
				k = $urandom_range(3);
				case ($urandom_range(2))
					0: return '0;
					1: return {1'b0, {(VALUE_BITS-1){1'b1}}} - VALUE_BITS'(k);
					default: return {1'b1, {(VALUE_BITS-1){1'b0}}} + VALUE_BITS'(k);
				endcase
			end
		endcase
	endfunction

	task automatic queue_number(logic [VALUE_BITS-1:0] number);
		numbers_to_send.push_back(number);
		queued_count++;
	endtask

	task automatic queue_random_numbers(int count);
		repeat (count) queue_number(pick_number());
	endtask

	task automatic note_error(string msg);
		error_count++;
		if (error_count <= MAX_REPORTS)
			$display("mismatch at cycle %0d: %s", cycle_count, msg);
	endtask

	// Sender: a transaction stays offered until accepted, then the next one
	// may follow in the very next cycle or after a random gap.
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_fire) begin
			if (numbers_to_send.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
				in_valid <= 1'b1;
				value <= numbers_to_send.pop_front();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Long receiver hold-off, counted here so the stimulus can keep running.
	always @(negedge clk) begin
		if (hold_served != hold_request) begin
			hold_left <= HOLD_CYCLES;
			hold_served <= hold_request;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	always @(negedge clk) begin
		if (!arst_n)
			out_ready <= 1'b0;
		else
			out_ready <= hold_left == 0 && hold_served == hold_request &&
				$urandom_range(99) >= rx_idle_pct;
	end

	always @(posedge clk) begin
		text_char_t due;
		if (!arst_n) begin
			in_fire <= 1'b0;
		end else begin
			if (out_valid === 1'b1 && out_ready) begin
				chars_checked++;
				if (pending_text.size() == 0) begin
					note_error($sformatf("unexpected character %0d last %0b", character, last));
				end else begin
					due = pending_text.pop_front();
					if (character !== due.code || last !== due.last_flag)
						note_error($sformatf("expected character %0d last %0b, got %0d last %0b",
							due.code, due.last_flag, character, last));
				end
			end
			if (in_valid && in_ready === 1'b1) begin
				append_decimal_text(value);
				accepted_count++;
				if (value[VALUE_BITS-1])
					negative_count++;
			end
			in_fire <= in_valid && in_ready === 1'b1;
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d characters still due",
				cycle_count, pending_text.size());
			$display("FAIL signed_integer_to_decimal_ascii_unit");
			$finish;
		end
	end

	initial begin
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		tx_idle_pct = 9;
		rx_idle_pct = 66;
		queue_number(32'd0);
		queue_number(32'd1);
		queue_number(-32'sd1);
		queue_number(32'd9);
		queue_number(32'd10);
		queue_number(-32'sd10);
		queue_number(32'd99);
		queue_number(32'd100);
		queue_number(-32'sd7);
		queue_number(32'd12345);
		queue_number(32'd999_999_999);
		queue_number(32'd1_000_000_000);
		queue_number(-32'sd999_999_999);
		queue_number(-32'sd1_000_000_000);
		queue_number(32'd1_999_999_999);
		queue_number(32'h7fff_ffff);
		queue_number(32'h8000_0000);
		queue_number(32'h8000_0001);
		queue_number(32'h5555_5555);
		queue_number(32'haaaa_aaaa);
		queue_number(32'd0);
		queue_number(32'd1_000_000_001);
		queue_random_numbers(130);
		wait (accepted_count == queued_count);

		tx_idle_pct = 66;
		rx_idle_pct = 9;
		queue_random_numbers(130);
		wait (accepted_count == queued_count);

		// No idling: hold the receiver off while numbers keep coming, so the
		// output register fills and the input stalls.
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		queue_random_numbers(130);
		wait (accepted_count >= queued_count - 110);
		hold_request++;
		wait (hold_served == hold_request && hold_left == 0);
		wait (accepted_count == queued_count);

		wait (pending_text.size() == 0);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (pending_text.size() != 0)
			note_error($sformatf("%0d characters never arrived", pending_text.size()));

		$display("converted %0d numbers (%0d negative) into %0d checked characters,",
			accepted_count, negative_count, chars_checked);
		$display("with idle mixes on both sides and one %0d-cycle receiver stall",
			HOLD_CYCLES);
		if (error_count == 0)
			$display("PASS signed_integer_to_decimal_ascii_unit");
		else
			$display("FAIL signed_integer_to_decimal_ascii_unit");
		$finish;
	end

endmodule

FILE: files.f
hw/rtl/sd2a_pkg.sv
hw/rtl/sd2a_dabble.sv
hw/rtl/signed_integer_to_decimal_ascii_unit.sv
sim/signed_integer_to_decimal_ascii_unit_test.sv
